@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the resequencer RTL. All are clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define FHR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define FHR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ src/fhr_pkg.sv @@
// ----------------------------------------------------------------------------
// fhr_pkg
// Types, status codes and default sizes of the holdback resequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fhr_pkg;

  localparam int DEF_NUM_SENDERS = 8;
  localparam int DEF_NUM_GROUPS  = 20;
  localparam int DEF_WINDOW      = 16;

  // Reciprocal scaling for the slot (seq mod window) calculation
  localparam int RECIP_SH = 22;
  localparam int PROD_W   = 16 + RECIP_SH;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_HELD      = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  typedef struct packed {
    logic [2:0]  sender;
    logic [4:0]  group;
    logic [15:0] seq_num;
    logic [15:0] msg_handle;
  } msg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [4:0]  out_group;
    logic [2:0]  out_sender;
    logic [15:0] out_seq;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ src/fhr_ram.sv @@
// ----------------------------------------------------------------------------
// fhr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fhr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/fifo_holdback_resequencer_unit.sv @@
// ----------------------------------------------------------------------------
// fifo_holdback_resequencer_unit
// Per sender/group FIFO resequencer with a holdback window of message handles.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------------
//   msg     | in  | msg_valid/msg_stall   | sender, group, seq_num, handle
//   result  | out | result_valid/stall    | status, handle, group, sender,
//           |     |                       | seq, last
//
// Sequence: a transfer in is followed by S_MUL, S_QW, S_SLOT, S_CLASS and
//   S_DECIDE (pair index, slot by reciprocal multiply, delivered-seq read,
//   holdback read, decide); each released held message adds S_RELRD and
//   S_CHK (holdback RAM read and lookahead), paced by that RAM's read port.
// Reset: a clearing pass over all PAIRS * 2**SLOT_W holdback addresses (2560
//   at defaults) zeroes delivered sequence numbers and holdback valid bits;
//   msg_stall is high throughout.
// Stalls: one output register; the sequencer waits while it is full and
//   result_stall is high. A new item is taken while the last result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fifo_holdback_resequencer_unit #(
  parameter int NUM_SENDERS = fhr_pkg::DEF_NUM_SENDERS,
  parameter int NUM_GROUPS  = fhr_pkg::DEF_NUM_GROUPS,
  parameter int WINDOW      = fhr_pkg::DEF_WINDOW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  fhr_pkg::msg_t    msg,
  output logic             result_valid,
  input  logic             result_stall,
  output fhr_pkg::result_t result
);

  localparam int PAIRS      = NUM_SENDERS * NUM_GROUPS;
  localparam int PAIR_W     = $clog2(PAIRS);
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int HA_W       = PAIR_W + SLOT_W;
  localparam int HELD_DEPTH = PAIRS * (2 ** SLOT_W);
  localparam int N_W        = $clog2(WINDOW + 1);
  localparam int RSH        = fhr_pkg::RECIP_SH;
  localparam int PROD_W     = fhr_pkg::PROD_W;

  // floor(2**RSH / WINDOW): quotient estimate is exact or one short
  localparam logic [RSH-1:0] RECIP_V = RSH'((2 ** RSH) / WINDOW);
  localparam logic [6:0]     WIN7    = 7'(WINDOW);
  localparam logic [15:0]    WIN16   = 16'(WINDOW);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_QW     = 4'd3;
  localparam logic [3:0] S_SLOT   = 4'd4;
  localparam logic [3:0] S_CLASS  = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_RELRD  = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;

  // Slot of the sequence number after q, whose slot is s. The 16-bit wrap
  // restarts the slot at zero, as seq mod WINDOW does.
  function automatic logic [SLOT_W-1:0] slot_after(input logic [SLOT_W-1:0] s,
                                                   input logic [15:0] q);
    if (q == 16'hFFFF) begin
      return '0;
    end
    if (32'(s) == WINDOW - 1) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // Sequencer and captured item
  logic [3:0]        state;
  logic [HA_W-1:0]   clr;
  logic [2:0]        sender_r;
  logic [4:0]        group_r;
  logic [15:0]       seq_r;
  logic [15:0]       hdl_r;
  logic              oor_r;
  logic [PAIR_W-1:0] pair_r;
  logic [PROD_W-1:0] prod_r;
  logic [15:0]       qw_r;
  logic [SLOT_W-1:0] slot_r;
  logic [15:0]       d_r;

  // Release walk: the entry about to be delivered
  logic [SLOT_W-1:0] pend_slot;
  logic [15:0]       pend_seq;
  logic [15:0]       pend_hdl;
  logic [N_W-1:0]    n_cnt;

  logic              out_valid;
  fhr_pkg::result_t  out_r;

  // Datapath
  logic [12:0]       pair_full;
  logic              oor_in;
  logic [PROD_W-1:0] prod_full;
  logic [15:0]       q_est;
  logic [22:0]       qw_full;
  logic [15:0]       r_diff;
  logic [15:0]       r_fix;
  logic              can_emit;
  logic              chk_last;
  logic [SLOT_W-1:0] rd_slot;
  logic [HA_W-1:0]   held_raddr;
  logic [HA_W-1:0]   held_waddr;

  // RAM ports
  logic              del_we;
  logic [PAIR_W-1:0] del_waddr;
  logic [15:0]       del_wdata;
  logic [15:0]       del_rdata;
  logic              vld_we;
  logic              vld_wdata;
  logic              vld_rdata;
  logic              hdl_we;
  logic [15:0]       hdl_rdata;

  logic              emit;
  fhr_pkg::result_t  emit_item;

  assign msg_stall    = (state != S_IDLE);
  assign result_valid = out_valid;
  assign result       = out_r;
  assign can_emit     = !out_valid || !result_stall;

  assign pair_full = 13'(sender_r) * 13'(NUM_GROUPS) + 13'(group_r);
  assign oor_in    = (32'(sender_r) >= NUM_SENDERS) || (32'(group_r) >= NUM_GROUPS);

  // seq mod WINDOW: multiply by reciprocal, back-multiply, one correction
  assign prod_full = seq_r * RECIP_V;
  assign q_est     = prod_r[RSH +: 16];
  assign qw_full   = q_est * WIN7;
  assign r_diff    = seq_r - qw_r;
  assign r_fix     = (r_diff >= WIN16) ? (r_diff - WIN16) : r_diff;

  // Holdback read address: next slot when delivering, own slot otherwise
  always_comb begin
    if (state == S_RELRD || state == S_CHK) begin
      rd_slot = slot_after(pend_slot, pend_seq);
    end else if (d_r == 16'd1) begin
      rd_slot = slot_after(slot_r, seq_r);
    end else begin
      rd_slot = slot_r;
    end
  end

  assign held_raddr = {pair_r, rd_slot};
  assign held_waddr = (state == S_CLEAR) ? clr : held_raddr;

  // Next entry released only if valid and the run has room left
  assign chk_last = !(vld_rdata && ((32'(n_cnt) + 1) < WINDOW));

  always_comb begin
    del_we    = 1'b0;
    del_waddr = pair_r;
    del_wdata = seq_r;
    vld_we    = 1'b0;
    vld_wdata = 1'b0;
    hdl_we    = 1'b0;
    emit      = 1'b0;
    emit_item.status     = fhr_pkg::ST_BEYOND;
    emit_item.out_handle = hdl_r;
    emit_item.out_group  = group_r;
    emit_item.out_sender = sender_r;
    emit_item.out_seq    = seq_r;
    emit_item.last       = 1'b1;
    unique case (state)
      S_CLEAR: begin
        vld_we    = 1'b1;
        del_we    = (32'(clr) < PAIRS);
        del_waddr = clr[PAIR_W-1:0];
        del_wdata = '0;
      end
      S_DECIDE: begin
        if (can_emit) begin
          emit = 1'b1;
          if (oor_r) begin
            emit_item.status = fhr_pkg::ST_BEYOND;
          end else if (d_r == 16'd1) begin
            emit_item.status = fhr_pkg::ST_DELIVERED;
            emit_item.last   = !vld_rdata;
            del_we           = 1'b1;
            vld_we           = vld_rdata;
          end else if (d_r >= 16'd2 && d_r <= WIN16) begin
            if (vld_rdata) begin
              emit_item.status = fhr_pkg::ST_DUP;
            end else begin
              emit_item.status = fhr_pkg::ST_HELD;
              vld_we           = 1'b1;
              vld_wdata        = 1'b1;
              hdl_we           = 1'b1;
            end
          end else if (d_r == 16'd0 || d_r[15]) begin
            emit_item.status = fhr_pkg::ST_DUP;
          end else begin
            emit_item.status = fhr_pkg::ST_BEYOND;
          end
        end
      end
      S_CHK: begin
        if (can_emit) begin
          emit                 = 1'b1;
          emit_item.status     = fhr_pkg::ST_DELIVERED;
          emit_item.out_handle = pend_hdl;
          emit_item.out_seq    = pend_seq;
          emit_item.last       = chk_last;
          del_we               = 1'b1;
          del_wdata            = pend_seq;
          vld_we               = !chk_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_r     <= emit_item;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == HA_W'(HELD_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (msg_valid) begin
            sender_r <= msg.sender;
            group_r  <= msg.group;
            seq_r    <= msg.seq_num;
            hdl_r    <= msg.msg_handle;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          pair_r <= pair_full[PAIR_W-1:0];
          oor_r  <= oor_in;
          prod_r <= prod_full;
          state  <= S_QW;
        end
        S_QW: begin
          qw_r  <= qw_full[15:0];
          state <= S_SLOT;
        end
        S_SLOT: begin
          slot_r <= r_fix[SLOT_W-1:0];
          d_r    <= seq_r - del_rdata;
          state  <= S_CLASS;
        end
        S_CLASS: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (can_emit) begin
            if (!oor_r && d_r == 16'd1 && vld_rdata) begin
              pend_slot <= rd_slot;
              pend_seq  <= seq_r + 16'd1;
              pend_hdl  <= hdl_rdata;
              n_cnt     <= N_W'(1);
              state     <= S_RELRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_RELRD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (can_emit) begin
            if (!chk_last) begin
              pend_slot <= rd_slot;
              pend_seq  <= pend_seq + 16'd1;
              pend_hdl  <= hdl_rdata;
              n_cnt     <= n_cnt + 1'b1;
              state     <= S_RELRD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Last delivered sequence number per pair
  fhr_ram #(
    .WIDTH(16),
    .DEPTH(PAIRS)
  ) u_del_ram (
    .clk  (clk),
    .we   (del_we),
    .waddr(del_waddr),
    .wdata(del_wdata),
    .raddr(pair_r),
    .rdata(del_rdata)
  );

  // Holdback valid bits, cleared by the pass after reset
  fhr_ram #(
    .WIDTH(1),
    .DEPTH(HELD_DEPTH)
  ) u_vld_ram (
    .clk  (clk),
    .we   (vld_we),
    .waddr(held_waddr),
    .wdata(vld_wdata),
    .raddr(held_raddr),
    .rdata(vld_rdata)
  );

  // Holdback handles; only read behind a set valid bit
  fhr_ram #(
    .WIDTH(16),
    .DEPTH(HELD_DEPTH)
  ) u_hdl_ram (
    .clk  (clk),
    .we   (hdl_we),
    .waddr(held_raddr),
    .wdata(hdl_r),
    .raddr(held_raddr),
    .rdata(hdl_rdata)
  );

  // Reset always restarts the clearing pass with the output empty
  `FHR_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR) && !result_valid, "reset did not restart clearing")
  // Nothing leaves the block before the clearing pass completes
  `FHR_ASSERT(a_no_result_clearing, (state == S_CLEAR) |-> !result_valid, "result during clearing pass")
  // A result that is not last always continues the release walk
  `FHR_ASSERT(a_run_continues, emit && !emit_item.last |=> state == S_RELRD, "release walk lost")
  // A run never reaches past the window
  `FHR_ASSERT(a_run_bounded, (state == S_CHK) |-> ((32'(n_cnt) + 0) < WINDOW), "run longer than window")

endmodule

`default_nettype wire

@@ test/fhr_resequencer_checker.sv @@
// ----------------------------------------------------------------------------
// fhr_resequencer_checker
// Watches both channels of the holdback resequencer, predicts its reports and
// compares each result transfer with the oldest one still due.
// ----------------------------------------------------------------------------
module fhr_resequencer_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  input  logic             msg_stall,
  input  fhr_pkg::msg_t    msg,
  input  logic             result_valid,
  input  logic             result_stall,
  input  fhr_pkg::result_t result,
  output int               fail_count,
  output int               results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SENDERS = fhr_pkg::DEF_NUM_SENDERS;
  localparam int NUM_GROUPS  = fhr_pkg::DEF_NUM_GROUPS;
  localparam int WINDOW      = fhr_pkg::DEF_WINDOW;
  localparam int NUM_PAIRS   = NUM_SENDERS * NUM_GROUPS;

  logic [15:0]      last_delivered [NUM_PAIRS];
  bit               slot_held      [NUM_PAIRS * WINDOW];
  logic [15:0]      slot_handle    [NUM_PAIRS * WINDOW];
  fhr_pkg::result_t due_results [$];
  int               mismatches = 0;

  function automatic int slot_of(int pair, logic [15:0] seq);
    return pair * WINDOW + int'(seq) % WINDOW;
  endfunction

  task automatic post_result(input fhr_pkg::msg_t m, input logic [1:0] st,
                             input logic [15:0] hdl, input logic [15:0] seq,
                             input logic fin);
    fhr_pkg::result_t r;
    r.status     = st;
    r.out_handle = hdl;
    r.out_group  = m.group;
    r.out_sender = m.sender;
    r.out_seq    = seq;
    r.last       = fin;
    due_results = {due_results, r};
  endtask

  // Works out every report caused by one arriving message.
  task automatic resequence_msg(input fhr_pkg::msg_t m);
    int          pair;
    int          count;
    logic [15:0] gap;
    logic [15:0] nxt;
    logic [15:0] hdl;
    if (int'(m.sender) >= NUM_SENDERS || int'(m.group) >= NUM_GROUPS) begin
      post_result(m, fhr_pkg::ST_BEYOND, m.msg_handle, m.seq_num, 1'b1);
      return;
    end
    pair = int'(m.sender) * NUM_GROUPS + int'(m.group);
    gap  = m.seq_num - last_delivered[pair];
    if (gap == 16'd1) begin
      last_delivered[pair] = m.seq_num;
      count = 1;
      nxt   = m.seq_num + 16'd1;
      post_result(m, fhr_pkg::ST_DELIVERED, m.msg_handle, m.seq_num,
                  count >= WINDOW || !slot_held[slot_of(pair, nxt)]);
      // release the run of held messages that now follows without a gap
      while (count < WINDOW && slot_held[slot_of(pair, nxt)]) begin
        hdl = slot_handle[slot_of(pair, nxt)];
        slot_held[slot_of(pair, nxt)] = 1'b0;
        last_delivered[pair] = nxt;
        count++;
        post_result(m, fhr_pkg::ST_DELIVERED, hdl, nxt,
                    count >= WINDOW || !slot_held[slot_of(pair, nxt + 16'd1)]);
        nxt = nxt + 16'd1;
      end
    end else if (gap >= 16'd2 && gap <= 16'(WINDOW)) begin
      if (slot_held[slot_of(pair, m.seq_num)]) begin
        post_result(m, fhr_pkg::ST_DUP, m.msg_handle, m.seq_num, 1'b1);
      end else begin
        slot_held[slot_of(pair, m.seq_num)]   = 1'b1;
        slot_handle[slot_of(pair, m.seq_num)] = m.msg_handle;
        post_result(m, fhr_pkg::ST_HELD, m.msg_handle, m.seq_num, 1'b1);
      end
    end else if (gap == 16'd0 || gap >= 16'h8000) begin
      post_result(m, fhr_pkg::ST_DUP, m.msg_handle, m.seq_num, 1'b1);
    end else begin
      post_result(m, fhr_pkg::ST_BEYOND, m.msg_handle, m.seq_num, 1'b1);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fhr_pkg::result_t want;
    if (rst) begin
      foreach (last_delivered[i]) last_delivered[i] = '0;
      foreach (slot_held[i]) slot_held[i] = 1'b0;
      due_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing due: %p", result);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status",     16'(want.status),     16'(result.status));
          check_field("out_handle", want.out_handle,      result.out_handle);
          check_field("out_group",  16'(want.out_group),  16'(result.out_group));
          check_field("out_sender", 16'(want.out_sender), 16'(result.out_sender));
          check_field("out_seq",    want.out_seq,         result.out_seq);
          check_field("last",       16'(want.last),       16'(result.last));
        end
      end
      if (msg_valid && !msg_stall) resequence_msg(msg);
    end
    fail_count      <= mismatches;
    results_pending <= due_results.size();
  end

endmodule

@@ test/fifo_holdback_resequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// fifo_holdback_resequencer_unit_tb
// Drives directed and random message traffic into the holdback resequencer
// under varying sender gaps and receiver stalls; a checker beside the block
// predicts every report and flags mismatches.
// ----------------------------------------------------------------------------
module fifo_holdback_resequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_GROUPS   = fhr_pkg::DEF_NUM_GROUPS;
  localparam int WINDOW       = fhr_pkg::DEF_WINDOW;
  localparam int NUM_PAIRS    = fhr_pkg::DEF_NUM_SENDERS * NUM_GROUPS;
  localparam int PHASE_ITEMS  = 32;
  // margin after the backlog drains; a full run of releases is well under
  // this
  localparam int SETTLE_CYCLES = 60;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             msg_valid    = 1'b0;
  fhr_pkg::msg_t    msg          = '0;
  logic             result_stall = 1'b0;
  logic             msg_stall;
  logic             result_valid;
  fhr_pkg::result_t result;

  int fail_count;
  int results_pending;

  // percentages of cycles the sender idles / the receiver stalls
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // last sequence number already delivered, per pair, as the traffic plans it
  logic [15:0] pair_base [NUM_PAIRS];

  always #10 clk = ~clk;

  always @(posedge clk) result_stall <= ($urandom_range(99) < recv_stall_pct);

  fifo_holdback_resequencer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .msg          (msg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  fhr_resequencer_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .msg_valid       (msg_valid),
    .msg_stall       (msg_stall),
    .msg             (msg),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result          (result),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // One message transfer. Random idle cycles go in front; valid stays high
  // and the payload steady until the block stops stalling.
  task automatic send_msg(input logic [2:0] snd, input logic [4:0] grp,
                          input logic [15:0] seq, input logic [15:0] hdl);
    fhr_pkg::msg_t m;
    m.sender     = snd;
    m.group      = grp;
    m.seq_num    = seq;
    m.msg_handle = hdl;
    while ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= m;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted report has come out.
  task automatic drain();
    msg_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A contiguous run of sequence numbers for one pair, sent shuffled so most
  // are held first and released in a chain. Now and then a copy of one
  // already sent goes in as well (slot taken or stale).
  task automatic send_block(inout int sent);
    logic [2:0]  snd;
    logic [4:0]  grp;
    logic [15:0] seqs [WINDOW];
    logic [15:0] tmp;
    int          pair;
    int          k;
    int          j;
    snd  = 3'($urandom_range(7));
    grp  = 5'($urandom_range(NUM_GROUPS - 1));
    pair = int'(snd) * NUM_GROUPS + int'(grp);
    k    = ($urandom_range(3) == 0) ? $urandom_range(WINDOW, 7) : $urandom_range(6, 1);
    for (int i = 0; i < k; i++) seqs[i] = pair_base[pair] + 16'(i + 1);
    for (int i = k - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
    for (int i = 0; i < k; i++) begin
      send_msg(snd, grp, seqs[i], 16'($urandom));
      sent++;
      if ($urandom_range(7) == 0) begin
        send_msg(snd, grp, seqs[$urandom_range(i)], 16'($urandom));
        sent++;
      end
    end
    pair_base[pair] = pair_base[pair] + 16'(k);
  endtask

  // Messages off the ordered path: bad group, too far ahead, stale, or fully
  // random numbering.
  task automatic send_noise();
    logic [2:0]  snd;
    logic [4:0]  grp;
    logic [15:0] base;
    snd  = 3'($urandom_range(7));
    grp  = 5'($urandom_range(NUM_GROUPS - 1));
    base = pair_base[int'(snd) * NUM_GROUPS + int'(grp)];
    case ($urandom_range(3))
      0: begin
        send_msg(snd, 5'($urandom_range(31, NUM_GROUPS)), 16'($urandom), 16'($urandom));
      end
      1: begin
        send_msg(snd, grp, base + 16'($urandom_range(16'h7FFF, WINDOW + 1)), 16'($urandom));
      end
      2: begin
        send_msg(snd, grp, base - 16'($urandom_range(16'h7FFF)), 16'($urandom));
      end
      default: begin
        send_msg(snd, grp, 16'($urandom), 16'($urandom));
      end
    endcase
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int sent;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(99) < 20) begin
        send_noise();
        sent++;
      end else begin
        send_block(sent);
      end
    end
    // sender pauses for the whole backlog before the next phase
    drain();
  endtask

  initial begin
    foreach (pair_base[i]) pair_base[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, pair (0,0): next expected, then repeats, stale and
    // far-ahead numbers either side of the half-range split, a window
    // overrun, a hold and a second copy into the taken slot.
    send_msg(3'd0, 5'd0, 16'd1,      16'h0000);
    send_msg(3'd0, 5'd0, 16'd1,      16'hFFFF);
    send_msg(3'd0, 5'd0, 16'h8001,   16'hA5A5);
    send_msg(3'd0, 5'd0, 16'h8000,   16'h5A5A);
    send_msg(3'd0, 5'd0, 16'd18,     16'h1234);
    send_msg(3'd0, 5'd0, 16'd3,      16'hFFFF);
    send_msg(3'd0, 5'd0, 16'd3,      16'h0001);
    pair_base[0] = 16'd1;
    // group beyond the configured count, both ends of the unused range
    send_msg(3'd7, 5'd31, 16'hFFFF,  16'hFFFF);
    send_msg(3'd0, 5'd20, 16'h0000,  16'h0000);
    // pair (7,19): fill the whole window backwards, the far edge first,
    // then the missing head releases every held message in one burst
    for (int s = WINDOW; s >= 2; s--) send_msg(3'd7, 5'd19, 16'(s), 16'(16'hF000 + s));
    send_msg(3'd7, 5'd19, 16'd1, 16'hBEEF);
    pair_base[NUM_PAIRS - 1] = 16'(WINDOW);
    drain();

    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(18, 18);

    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard: covers the reset clearing pass and a worst-case run with
  // room to spare.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
